[rtl/arp_pkg.sv]
// Shared types, constants and helper functions for the ARP request responder.
`timescale 1ns / 1ps

package arp_pkg;

   // Frame geometry
   localparam int REPLY_BYTES = 42;
   localparam int POS_W       = 6;
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(REPLY_BYTES - 1);
   localparam logic [POS_W-1:0] FULL_POS = POS_W'(REPLY_BYTES);

   // Header offsets
   localparam logic [POS_W-1:0] ETYPE_HI_POS = 6'd12;
   localparam logic [POS_W-1:0] ETYPE_LO_POS = 6'd13;
   localparam logic [POS_W-1:0] TPA_POS      = 6'd38;
   localparam logic [7:0] ETYPE_ARP_HI = 8'h08;
   localparam logic [7:0] ETYPE_ARP_LO = 8'h06;
   localparam logic [7:0] OPCODE_HI    = 8'h00;
   localparam logic [7:0] OPCODE_LO    = 8'h02;

   // Configuration register map
   localparam int MAC_W     = 48;
   localparam int IP_W      = 32;
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_MAC = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_IP  = 1'd1;

   // Controller to datapath commands
   typedef struct packed {
      logic rx_take;    // store and check the current input byte
      logic rx_clear;   // frame done: rewind position and check flag
      logic tx_start;   // begin a reply: read for reply byte 0
      logic tx_advance; // next reply byte: read for it
      logic load_out;   // load the output register from read data
   } arp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic frame_match; // current byte, if it ends the frame, earns a reply
      logic tx_last;     // reply byte under way is the final one
   } arp_sts_type;

   // Header store address that feeds reply byte k
   function automatic logic [POS_W-1:0] store_addr(input logic [POS_W-1:0] k);
      logic [POS_W-1:0] addr;
      addr = '0;
      if (k < 6'd6) begin
         addr = POS_W'(k + 6'd6);
      end else if (k < 6'd20) begin
         addr = k;
      end else if (k >= 6'd32) begin
         addr = POS_W'(k - 6'd10);
      end
      return addr;
   endfunction

   // Byte i of a MAC address, first byte most significant
   function automatic logic [7:0] mac_byte(input logic [MAC_W-1:0] mac,
                                           input logic [2:0] i);
      logic [7:0] b;
      case (i)
         3'd0:    b = mac[47:40];
         3'd1:    b = mac[39:32];
         3'd2:    b = mac[31:24];
         3'd3:    b = mac[23:16];
         3'd4:    b = mac[15:8];
         3'd5:    b = mac[7:0];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // Byte i of an IPv4 address, first byte most significant
   function automatic logic [7:0] ip_byte(input logic [IP_W-1:0] ip,
                                          input logic [1:0] i);
      logic [7:0] b;
      case (i)
         2'd0:    b = ip[31:24];
         2'd1:    b = ip[23:16];
         2'd2:    b = ip[15:8];
         2'd3:    b = ip[7:0];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

[rtl/arp_ctrl.sv]
// Controller state machine: receive, then load and send each reply byte.
`timescale 1ns / 1ps

module arp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_frame_end,
   input  logic                 rsp_stall,
   input  arp_pkg::arp_sts_type sts,
   output arp_pkg::arp_cmd_type cmd,
   output logic                 req_stall,
   output logic                 rsp_valid
);
   import arp_pkg::*;

   typedef enum logic [1:0] {
      ST_RECV,
      ST_LOAD,
      ST_SEND
   } state_type;

   state_type state_ff, state_in;
   logic      req_stall_ff, req_stall_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Decode commands and next state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_RECV: begin
            if (req_valid && !req_stall_ff) begin
               cmd.rx_take = 1'b1;
               if (req_frame_end) begin
                  cmd.rx_clear = 1'b1;
                  if (sts.frame_match) begin
                     cmd.tx_start = 1'b1;
                     state_in     = ST_LOAD;
                  end
               end
            end
         end
         ST_LOAD: begin
            cmd.load_out = 1'b1;
            state_in     = ST_SEND;
         end
         ST_SEND: begin
            if (!rsp_stall) begin
               if (sts.tx_last) begin
                  state_in = ST_RECV;
               end else begin
                  cmd.tx_advance = 1'b1;
                  state_in       = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_RECV;
         end
      endcase
      req_stall_in = (state_in != ST_RECV);
      rsp_valid_in = (state_in == ST_SEND);
   end

   // Hold state and registered handshake outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RECV;
         req_stall_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= req_stall_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = req_stall_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/arp_dpath.sv]
// Datapath: station registers, header memory, frame checks and reply byte mux.
`timescale 1ns / 1ps

module arp_dpath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wen,
   input  logic [arp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [arp_pkg::MAC_W-1:0]      csr_wdata,
   input  logic [7:0]                     req_frame_byte,
   input  arp_pkg::arp_cmd_type           cmd,
   output arp_pkg::arp_sts_type           sts,
   output logic [7:0]                     rsp_reply_byte,
   output logic                           rsp_reply_last
);
   import arp_pkg::*;

   logic [MAC_W-1:0] own_mac_ff;
   logic [IP_W-1:0]  own_ip_ff;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             ok_ff, ok_in;
   logic [IP_W-1:0]  tpa_ff, tpa_in;
   logic [IP_W-1:0]  tpa_now;
   logic [POS_W-1:0] k_ff, k_in;
   logic [7:0]       hdr_mem [0:REPLY_BYTES-1];
   logic [7:0]       rd_data_ff;
   logic [POS_W-1:0] rd_k;
   logic [POS_W-1:0] rd_addr;
   logic             rd_en;
   logic             wr_en;
   logic             chk_en;
   logic [7:0]       chk_byte;
   logic             ok_now;
   logic [7:0]       out_byte_ff, out_byte_in;
   logic             out_last_ff;

   // Write station registers
   always_ff @(posedge clock) begin
      if (reset) begin
         own_mac_ff <= '0;
         own_ip_ff  <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_OWN_MAC: own_mac_ff <= csr_wdata;
            CSR_OWN_IP:  own_ip_ff  <= csr_wdata[IP_W-1:0];
            default:     own_mac_ff <= own_mac_ff;
         endcase
      end
   end

   // Check the ethertype as header bytes go by
   always_comb begin
      chk_en   = 1'b0;
      chk_byte = 8'h00;
      if (pos_ff == ETYPE_HI_POS) begin
         chk_en   = 1'b1;
         chk_byte = ETYPE_ARP_HI;
      end else if (pos_ff == ETYPE_LO_POS) begin
         chk_en   = 1'b1;
         chk_byte = ETYPE_ARP_LO;
      end
   end

   // Compare the captured target IP with own_ip at frame end
   assign tpa_now         = (pos_ff == LAST_POS) ? {tpa_ff[IP_W-9:0], req_frame_byte} : tpa_ff;
   assign ok_now          = ok_ff && !(chk_en && (req_frame_byte != chk_byte));
   assign sts.frame_match = (pos_ff >= LAST_POS) && ok_now && (tpa_now == own_ip_ff);
   assign sts.tx_last     = (k_ff == LAST_POS);

   // Advance receive position, check flag and target IP capture
   assign wr_en = cmd.rx_take && (pos_ff < FULL_POS);

   always_comb begin
      pos_in = pos_ff;
      ok_in  = ok_ff;
      tpa_in = tpa_ff;
      if (wr_en && (pos_ff >= TPA_POS)) begin
         tpa_in = {tpa_ff[IP_W-9:0], req_frame_byte};
      end
      if (cmd.rx_clear) begin
         pos_in = '0;
         ok_in  = 1'b1;
      end else if (cmd.rx_take) begin
         ok_in = ok_now;
         if (wr_en) begin
            pos_in = POS_W'(pos_ff + 6'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         ok_ff  <= 1'b1;
         tpa_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         ok_ff  <= ok_in;
         tpa_ff <= tpa_in;
      end
   end

   // Step the reply byte counter and pick the store address it needs
   assign rd_en   = cmd.tx_start || cmd.tx_advance;
   assign rd_k    = cmd.tx_start ? '0 : POS_W'(k_ff + 6'd1);
   assign rd_addr = store_addr(rd_k);
   assign k_in    = rd_en ? rd_k : k_ff;

   always_ff @(posedge clock) begin
      k_ff <= k_in;
   end

   // Header memory: write while receiving, read while replying
   always_ff @(posedge clock) begin
      if (wr_en) begin
         hdr_mem[pos_ff] <= req_frame_byte;
      end
      if (rd_en) begin
         rd_data_ff <= hdr_mem[rd_addr];
      end
   end

   // Select the reply byte
   always_comb begin
      if (k_ff < 6'd6) begin
         out_byte_in = rd_data_ff;
      end else if (k_ff < 6'd12) begin
         out_byte_in = mac_byte(own_mac_ff, 3'(k_ff - 6'd6));
      end else if (k_ff < 6'd20) begin
         out_byte_in = rd_data_ff;
      end else if (k_ff == 6'd20) begin
         out_byte_in = OPCODE_HI;
      end else if (k_ff == 6'd21) begin
         out_byte_in = OPCODE_LO;
      end else if (k_ff < 6'd28) begin
         out_byte_in = mac_byte(own_mac_ff, 3'(k_ff - 6'd22));
      end else if (k_ff < 6'd32) begin
         out_byte_in = ip_byte(own_ip_ff, 2'(k_ff - 6'd28));
      end else begin
         out_byte_in = rd_data_ff;
      end
   end

   // Load the output register; it holds while the transfer is stalled
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_byte_ff <= out_byte_in;
         out_last_ff <= sts.tx_last;
      end
   end

   assign rsp_reply_byte = out_byte_ff;
   assign rsp_reply_last = out_last_ff;

endmodule

[rtl/arp_request_responder.sv]
// Top level of the ARP request responder: controller, datapath and checks.
`timescale 1ns / 1ps

// Frame bytes are taken one per cycle with no gaps needed while no reply is
// under way; the input also stalls out of reset. The first 42 bytes land in a
// 42-entry header memory while the ethertype is checked on the fly and the ARP
// target IP bytes are captured in a register. When the final byte of a frame
// whose length (at least 42 bytes), ethertype (0x0806) and target IP (own_ip,
// compared at that byte) all match is taken, the input stalls and a 42-byte ARP
// reply goes out: each reply byte takes a header memory read, then the output
// register load, and is then held while the output stalls; the read for the
// next byte starts only once the current byte is taken. The memory needs no
// clearing after reset. Write own_mac (index 0) and own_ip (index 1) only while
// no reply is under way.
module arp_request_responder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wen,
   input  logic [arp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [arp_pkg::MAC_W-1:0]     csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_frame_byte,
   input  logic                          req_frame_end,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_reply_byte,
   output logic                          rsp_reply_last
);
   import arp_pkg::*;

   arp_cmd_type cmd;
   arp_sts_type sts;

   arp_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_frame_end (req_frame_end),
      .rsp_stall     (rsp_stall),
      .sts           (sts),
      .cmd           (cmd),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid)
   );

   arp_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .csr_wen        (csr_wen),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_frame_byte (req_frame_byte),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_reply_byte (rsp_reply_byte),
      .rsp_reply_last (rsp_reply_last)
   );

   // No input transfer while a reply byte is offered
   a_no_rx_during_tx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input accepted while reply under way");

   // The last reply byte ends the burst
   a_last_ends_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_reply_last) |=> !rsp_valid)
      else $error("reply continued after last byte");

   // Each reply byte transfer is followed by a load cycle
   a_load_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_reply_last) |=> (!rsp_valid && req_stall))
      else $error("reply byte sequencing broken");

   // A reply starts only right after a frame end transfer
   a_reply_start: assert property (@(posedge clock) disable iff (reset)
      ($rose(req_stall) && !$past(reset)) |-> $past(req_valid && req_frame_end))
      else $error("reply started without frame end");

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the ARP request responder: directed and random frames.
`timescale 1ns / 1ps

module testbench;

   localparam int HDR_BYTES = arp_pkg::REPLY_BYTES;
   localparam logic [15:0] ETYPE_ARP = {arp_pkg::ETYPE_ARP_HI, arp_pkg::ETYPE_ARP_LO};

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } reply_beat_type;

   // DUT connections, all inputs known from time zero
   logic                          clock          = 1'b0;
   logic                          reset          = 1'b1;
   logic                          csr_wen        = 1'b0;
   logic [arp_pkg::CSR_IDX_W-1:0] csr_index      = '0;
   logic [arp_pkg::MAC_W-1:0]     csr_wdata      = '0;
   logic                          req_valid      = 1'b0;
   logic                          req_stall;
   logic [7:0]                    req_frame_byte = 8'h00;
   logic                          req_frame_end  = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall      = 1'b0;
   logic [7:0]                    rsp_reply_byte;
   logic                          rsp_reply_last;

   // Predictor state: header copy, frame position and station addresses
   logic [7:0]  rx_header [HDR_BYTES];
   logic [5:0]  rx_count = '0;
   logic [47:0] station_mac = '0;
   logic [31:0] station_ip = '0;
   reply_beat_type expected_reply [$];

   // Frame under construction and idle controls
   logic [7:0] frame_buf [$];
   int send_idle_pct = 0;
   int stall_pct = 0;

   // Run statistics
   int errors = 0;
   int frames_sent = 0;
   int bytes_sent = 0;
   int replies_expected = 0;
   int beats_checked = 0;
   int csr_writes = 0;

   arp_request_responder i_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_wen        (csr_wen),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_frame_byte (req_frame_byte),
      .req_frame_end  (req_frame_end),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_reply_byte (rsp_reply_byte),
      .rsp_reply_last (rsp_reply_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Random receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
   end

   // Reply byte k built from the stored request and the station addresses
   function automatic logic [7:0] reply_octet(input int k);
      logic [7:0] v;
      if (k < 6) v = rx_header[k + 6];
      else if (k < 12) v = station_mac[8 * (11 - k) +: 8];
      else if (k < 20) v = rx_header[k];
      else if (k == 20) v = arp_pkg::OPCODE_HI;
      else if (k == 21) v = arp_pkg::OPCODE_LO;
      else if (k < 28) v = station_mac[8 * (27 - k) +: 8];
      else if (k < 32) v = station_ip[8 * (31 - k) +: 8];
      else v = rx_header[k - 10];
      return v;
   endfunction

   // Store one received byte; at frame end queue the reply it earns
   task automatic track_byte(input logic [7:0] b, input logic e);
      logic hit;
      if (rx_count < 6'(HDR_BYTES)) begin
         rx_header[rx_count] = b;
         rx_count++;
      end
      if (e) begin
         hit = rx_count == 6'(HDR_BYTES)
            && rx_header[12] == arp_pkg::ETYPE_ARP_HI
            && rx_header[13] == arp_pkg::ETYPE_ARP_LO
            && {rx_header[38], rx_header[39], rx_header[40], rx_header[41]} == station_ip;
         rx_count = '0;
         if (hit) begin
            replies_expected++;
            for (int k = 0; k < HDR_BYTES; k++)
               expected_reply.push_back('{reply_octet(k), k == HDR_BYTES - 1});
         end
      end
   endtask

   task automatic note_error(input string what, input reply_beat_type want,
                             input reply_beat_type got);
      errors++;
      if (errors <= 10)
         $display("%0t %s: expected byte %02h last %0b, got byte %02h last %0b",
                  $time, what, want.data, want.last, got.data, got.last);
   endtask

   // Compare each reply transfer with the oldest expected byte
   always @(posedge clock) begin : check_reply
      reply_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_reply.size() == 0) begin
            note_error("unexpected reply byte", '0, {rsp_reply_byte, rsp_reply_last});
         end else begin
            want = expected_reply.pop_front();
            beats_checked++;
            if (want.data !== rsp_reply_byte || want.last !== rsp_reply_last)
               note_error("reply byte mismatch", want, {rsp_reply_byte, rsp_reply_last});
         end
      end
   end

   // Drive one frame byte and hold it until the transfer completes
   task automatic send_byte(input logic [7:0] b, input logic e);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_frame_byte <= 8'($urandom);
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_frame_byte <= b;
      req_frame_end <= e;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
      track_byte(b, e);
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_buf.size(); i++)
         send_byte(frame_buf[i], i == frame_buf.size() - 1);
      frames_sent++;
   endtask

   // Fill a frame: random or constant bytes, then ethertype, opcode and target IP
   task automatic build_frame(input int len, input logic [15:0] etype, input logic [31:0] tpa,
                              input logic [15:0] oper, input int fill);
      int n;
      n = (len > HDR_BYTES) ? len : HDR_BYTES;
      frame_buf.delete();
      for (int i = 0; i < n; i++)
         frame_buf.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
      frame_buf[12] = etype[15:8];
      frame_buf[13] = etype[7:0];
      frame_buf[20] = oper[15:8];
      frame_buf[21] = oper[7:0];
      for (int j = 0; j < 4; j++)
         frame_buf[38 + j] = tpa[8 * (3 - j) +: 8];
      while (frame_buf.size() > len) void'(frame_buf.pop_back());
   endtask

   // Drop valid, drain all replies and let the block settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_reply.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(input logic [arp_pkg::CSR_IDX_W-1:0] idx, input logic [47:0] value);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
      if (idx == arp_pkg::CSR_OWN_MAC) station_mac = value;
      else station_ip = value[31:0];
      csr_writes++;
   endtask

   // Set both addresses; junk in the upper data bits of the IP write
   task automatic set_station(input logic [47:0] mac, input logic [31:0] ip);
      write_reg(arp_pkg::CSR_OWN_MAC, mac);
      write_reg(arp_pkg::CSR_OWN_IP, {16'($urandom), ip});
   endtask

   // Reset addresses are zero: a request for 0.0.0.0 is answered
   task automatic test_reset_defaults();
      build_frame(HDR_BYTES, ETYPE_ARP, 32'h0, 16'h0001, -1);
      send_frame();
      wait_idle();
   endtask

   // All-ones addresses, target IP, opcode and filler; the opcode is not checked
   task automatic test_field_extremes();
      set_station(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
      build_frame(HDR_BYTES, ETYPE_ARP, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
      send_frame();
      wait_idle();
   endtask

   // One byte short gives nothing; a longer frame is judged on the first 42 bytes
   task automatic test_frame_lengths();
      set_station({16'($urandom), 32'($urandom)}, 32'($urandom));
      build_frame(HDR_BYTES - 1, ETYPE_ARP, station_ip, 16'h0001, -1);
      send_frame();
      build_frame(HDR_BYTES + 1, ETYPE_ARP, station_ip, 16'h0001, -1);
      send_frame();
      wait_idle();
   endtask

   // Wrong ethertype or one wrong target IP bit gives nothing
   task automatic test_header_checks();
      set_station({16'($urandom), 32'($urandom)}, 32'($urandom));
      build_frame(HDR_BYTES, 16'h0800, station_ip, 16'h0001, -1);
      send_frame();
      build_frame(HDR_BYTES, ETYPE_ARP, station_ip ^ (32'h1 << $urandom_range(31)),
                  16'h0001, -1);
      send_frame();
      wait_idle();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 0;
      stall_pct = 0;
      test_reset_defaults();
      send_idle_pct = 55;
      stall_pct = 0;
      test_header_checks();
      send_idle_pct = 0;
      stall_pct = 55;
      test_frame_lengths();
      send_idle_pct = 38;
      stall_pct = 38;
      test_field_extremes();

      repeat (100) @(posedge clock);
      if (expected_reply.size() != 0) begin
         errors++;
         $display("%0d expected reply bytes never arrived", expected_reply.size());
      end
      $display("Sent %0d frames (%0d bytes) over %0d register writes and four idle mixes;",
               frames_sent, bytes_sent, csr_writes);
      $display("checked %0d reply bytes from %0d replies, %0d errors",
               beats_checked, replies_expected, errors);
      if (errors == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

   // Hard stop if the run hangs
   initial begin
      #5_000_000;
      $display("Timeout with %0d reply bytes outstanding", expected_reply.size());
      $display("testbench: FAIL");
      $finish;
   end

endmodule
